FILE: design/ihc_pkg.sv
package ihc_pkg;

	localparam int ByteW    = 8;
	localparam int WordW    = 2 * ByteW;
	localparam int PosW     = 6;
	localparam int SkipIdxW = 5;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 32;

	localparam logic [PosW-1:0]     PosMax        = {PosW{1'b1}};
	localparam logic                SkipEnableRst = 1'b1;
	localparam logic [SkipIdxW-1:0] SkipIndexRst  = SkipIdxW'(5);

	// Register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_SKIP_ENABLE = 2'd0,
		CFG_SKIP_INDEX  = 2'd1
	} cfg_idx_t;

	typedef logic [WordW-1:0] word_t;

	// Ones' complement add with end-around carry
	function automatic word_t ones_add(input word_t a, input word_t b);
		logic [WordW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WordW-1:0] + word_t'(s[WordW]);
	endfunction

endpackage

FILE: design/ihc_if.sv
interface ihc_hdr_if;
	logic                     valid;
	logic                     ready;
	logic [ihc_pkg::ByteW-1:0] first_byte;
	logic [ihc_pkg::ByteW-1:0] second_byte;
	logic                     single_byte;
	logic                     last;

	modport source (output valid, first_byte, second_byte, single_byte, last, input ready);
	modport sink   (input valid, first_byte, second_byte, single_byte, last, output ready);
endinterface

interface ihc_sum_if;
	logic                      valid;
	logic                      ready;
	logic [ihc_pkg::WordW-1:0] checksum;
	logic                      field_matches;

	modport source (output valid, checksum, field_matches, input ready);
	modport sink   (input valid, checksum, field_matches, output ready);
endinterface

interface ihc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ihc_pkg::CfgIdxW-1:0]  index;
	logic [ihc_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/ipv4_header_checksum.sv
// Internet checksum over an IPv4 header that arrives as one 16-bit word per item
// (first_byte high, second_byte low; single_byte pads a trailing byte with zero).
// The word at skip_index is captured instead of summed when skip_enable is set.
// On the item marked last the block emits the complemented sum and whether the
// captured field equals it, then clears its state for the next header. An item
// passes an input register and one 16-bit end-around-carry add into the result
// register; one item per cycle unless a stalled result blocks a last item.
// Configuration writes are always taken and should be made between headers.
module ipv4_header_checksum (
	input  logic            clk,
	input  logic            arst_n,
	ihc_hdr_if.sink         hdr_in,
	ihc_sum_if.source       sum_out,
	ihc_cfg_if.sink         cfg
);

	logic                             skip_enable_q;
	logic [ihc_pkg::SkipIdxW-1:0]     skip_index_q;

	logic                             valid_s1;
	ihc_pkg::word_t                   word_s1;
	logic                             last_s1;

	ihc_pkg::word_t                   running_sum_q;
	ihc_pkg::word_t                   captured_q;
	logic [ihc_pkg::PosW-1:0]         word_pos_q;

	logic                             out_valid_q;
	ihc_pkg::word_t                   checksum_q;
	logic                             matches_q;

	logic                             advance_s1;
	logic                             skip_hit;
	ihc_pkg::word_t                   sum_next;
	ihc_pkg::word_t                   capt_next;
	ihc_pkg::word_t                   ck_next;

	// Stage 1 moves on unless a last item waits on a full result register
	assign advance_s1   = valid_s1 && (!last_s1 || !out_valid_q || sum_out.ready);
	assign hdr_in.ready = !valid_s1 || advance_s1;
	assign cfg.ready    = 1'b1;

	assign skip_hit  = skip_enable_q && (word_pos_q == {1'b0, skip_index_q});
	assign sum_next  = skip_hit ? running_sum_q : ihc_pkg::ones_add(running_sum_q, word_s1);
	assign capt_next = skip_hit ? word_s1 : captured_q;
	assign ck_next   = ~sum_next;

	assign sum_out.valid         = out_valid_q;
	assign sum_out.checksum      = checksum_q;
	assign sum_out.field_matches = matches_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_enable_q <= ihc_pkg::SkipEnableRst;
			skip_index_q  <= ihc_pkg::SkipIndexRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				ihc_pkg::CFG_SKIP_ENABLE: skip_enable_q <= cfg.data[0];
				ihc_pkg::CFG_SKIP_INDEX:  skip_index_q  <= cfg.data[ihc_pkg::SkipIdxW-1:0];
				default: ;
			endcase
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_in.ready) begin
			valid_s1 <= hdr_in.valid;
		end
	end

	// Input register: payload, pad a single byte with zero
	always_ff @(posedge clk) begin
		if (hdr_in.valid && hdr_in.ready) begin
			word_s1 <= {hdr_in.first_byte,
				hdr_in.single_byte ? '0 : hdr_in.second_byte};
			last_s1 <= hdr_in.last;
		end
	end

	// Header state: accumulate, capture, clear after last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			captured_q    <= '0;
			word_pos_q    <= '0;
		end else if (advance_s1) begin
			if (last_s1) begin
				running_sum_q <= '0;
				captured_q    <= '0;
				word_pos_q    <= '0;
			end else begin
				running_sum_q <= sum_next;
				captured_q    <= capt_next;
				if (word_pos_q != ihc_pkg::PosMax) begin
					word_pos_q <= word_pos_q + 1'b1;
				end
			end
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (sum_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			checksum_q <= ck_next;
			matches_q  <= (capt_next == ck_next);
		end
	end

endmodule

FILE: design/ihc_checker.sv
module ihc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [ihc_pkg::WordW-1:0] out_checksum,
	input logic                      out_field_matches,
	input logic                      cfg_ready
);

	// An empty result register never holds back input
	a_in_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register empty");

	// Configuration writes are never refused
	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// A waiting result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_checksum)
			&& $stable(out_field_matches))
		else $error("result dropped or changed while stalled");

endmodule

bind ipv4_header_checksum ihc_checker u_ihc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_ready          (hdr_in.ready),
	.out_valid         (sum_out.valid),
	.out_ready         (sum_out.ready),
	.out_checksum      (sum_out.checksum),
	.out_field_matches (sum_out.field_matches),
	.cfg_ready         (cfg.ready)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	typedef logic [ihc_pkg::ByteW-1:0]   byte_t;
	typedef logic [ihc_pkg::PosW-1:0]    pos_t;
	typedef logic [ihc_pkg::CfgIdxW-1:0] cfg_addr_t;

	typedef struct packed {
		byte_t          fb;
		byte_t          sb;
		logic           single;
		logic           lst;
		bit             fixed;
		ihc_pkg::word_t ck;
		logic           m;
	} hdr_row_t;

	typedef struct {
		ihc_pkg::word_t ck;
		logic           m;
	} sum_rec_t;

	// Indexes past the register list; writes there must have no effect
	localparam cfg_addr_t CFG_SPARE_LO = cfg_addr_t'(2);
	localparam cfg_addr_t CFG_SPARE_HI = cfg_addr_t'(3);

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SEG_COUNT     = 8;
	localparam int SEG_ITEMS     = 100;
	localparam int MAX_WORDS     = 80;
	localparam int RANDOM_IDX    = -1;

	logic clk = 1'b0;
	logic arst_n;

	ihc_hdr_if hdr_bus ();
	ihc_sum_if sum_bus ();
	ihc_cfg_if cfg_bus ();

	ipv4_header_checksum dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr_in  (hdr_bus),
		.sum_out (sum_bus),
		.cfg     (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Checksum engine state as the block should hold it
	logic                         cfg_skip_en  = ihc_pkg::SkipEnableRst;
	logic [ihc_pkg::SkipIdxW-1:0] cfg_skip_idx = ihc_pkg::SkipIndexRst;
	ihc_pkg::word_t               sum_acc      = '0;
	pos_t                         pos_cnt      = '0;
	ihc_pkg::word_t               field_cap    = '0;

	sum_rec_t pending_sums [$];
	int       mismatch_cnt = 0;
	int       items_sent   = 0;
	int       tx_idle_pct  = 0;
	int       rx_idle_pct  = 0;
	int       cycle_cnt    = 0;

	// Header walks: extremes, a textbook IPv4 header, padded bytes
	hdr_row_t directed_rows [23] = '{
		'{8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0},
		'{8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1},
		'{8'hFF, 8'hAA, 1'b1, 1'b1, 1'b1, 16'h00FF, 1'b0},
		'{8'h45, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 8'h73, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h40, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h40, 8'h11, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hB8, 8'h61, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hC0, 8'hA8, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 8'h01, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hC0, 8'hA8, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 8'hC7, 1'b0, 1'b1, 1'b1, 16'hB861, 1'b1},
		'{8'h12, 8'h34, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hAB, 8'hCD, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{8'h01, 8'h02, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h03, 8'h04, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h05, 8'h06, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h07, 8'h08, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h09, 8'h0A, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'h5A, 8'h77, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{8'hEE, 8'h11, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0}
	};

	// Per-segment settings: skip enable, skip index, sender idle, receiver idle
	int seg_en  [SEG_COUNT] = '{1, 0, 1, 1, 0, 1, 1, 1};
	int seg_idx [SEG_COUNT] = '{5, 5, 0, 31, 31, RANDOM_IDX, 5, RANDOM_IDX};
	int seg_tx  [SEG_COUNT] = '{10, 10, 10, 84, 84, 84, 0, 0};
	int seg_rx  [SEG_COUNT] = '{84, 84, 84, 10, 10, 10, 0, 0};

	function automatic ihc_pkg::word_t add_carry(input ihc_pkg::word_t a,
			input ihc_pkg::word_t b);
		logic [ihc_pkg::WordW:0] s;
		s = {1'b0, a} + {1'b0, b};
		s = {1'b0, s[ihc_pkg::WordW-1:0]} + {{ihc_pkg::WordW{1'b0}}, s[ihc_pkg::WordW]};
		return s[ihc_pkg::WordW-1:0];
	endfunction

	// Fold one word into the expected state; report the result on the last word
	task automatic absorb_word(input byte_t fb, input byte_t sb, input logic single,
			input logic lst, output bit emits, output sum_rec_t rec);
		ihc_pkg::word_t w;
		w = {fb, single ? byte_t'(0) : sb};
		if (cfg_skip_en && pos_cnt == pos_t'(cfg_skip_idx)) begin
			field_cap = w;
		end else begin
			sum_acc = add_carry(sum_acc, w);
		end
		if (pos_cnt != ihc_pkg::PosMax) begin
			pos_cnt = pos_cnt + 1'b1;
		end
		emits  = lst;
		rec.ck = ~sum_acc;
		rec.m  = (field_cap == ~sum_acc);
		if (lst) begin
			sum_acc   = '0;
			pos_cnt   = '0;
			field_cap = '0;
		end
	endtask

	// Offer one header word, idling first at random, and log its expected result
	task automatic push_word(input byte_t fb, input byte_t sb, input logic single,
			input logic lst, input bit fixed, input ihc_pkg::word_t fixed_ck,
			input logic fixed_m);
		bit       emits;
		sum_rec_t rec;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			hdr_bus.valid <= 1'b0;
			@(posedge clk);
		end
		hdr_bus.valid       <= 1'b1;
		hdr_bus.first_byte  <= fb;
		hdr_bus.second_byte <= sb;
		hdr_bus.single_byte <= single;
		hdr_bus.last        <= lst;
		@(posedge clk);
		while (!hdr_bus.ready) begin
			@(posedge clk);
		end
		items_sent++;
		absorb_word(fb, sb, single, lst, emits, rec);
		if (emits) begin
			if (fixed) begin
				rec.ck = fixed_ck;
				rec.m  = fixed_m;
			end
			pending_sums.push_back(rec);
		end
	endtask

	// Drop valid and hold until every expected result has been taken
	task automatic drain_sums();
		hdr_bus.valid <= 1'b0;
		while (pending_sums.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_addr_t idx,
			input logic [ihc_pkg::CfgDataW-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready) begin
			@(posedge clk);
		end
		case (idx)
			ihc_pkg::CFG_SKIP_ENABLE: cfg_skip_en  = data[0];
			ihc_pkg::CFG_SKIP_INDEX:  cfg_skip_idx = data[ihc_pkg::SkipIdxW-1:0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Build one random header: mostly well formed, some long, some noise
	task automatic send_header();
		byte_t          hi_b [MAX_WORDS];
		byte_t          lo_b [MAX_WORDS];
		logic           sg   [MAX_WORDS];
		int             kind;
		int             len;
		ihc_pkg::word_t acc;
		ihc_pkg::word_t fld;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			len = (cfg_skip_en ? int'(cfg_skip_idx) + 1 : 1) + $urandom_range(0, 8);
		end else if (kind < 70) begin
			len = $urandom_range(60, 70);
		end else begin
			len = $urandom_range(1, 6);
		end
		for (int p = 0; p < len; p++) begin
			hi_b[p] = byte_t'($urandom);
			lo_b[p] = byte_t'($urandom);
			if ($urandom_range(0, 15) == 0) begin
				hi_b[p] = $urandom_range(0, 1) ? '1 : '0;
			end
			if ($urandom_range(0, 15) == 0) begin
				lo_b[p] = $urandom_range(0, 1) ? '1 : '0;
			end
			if (kind >= 70) begin
				sg[p] = ($urandom_range(0, 3) == 0);
			end else begin
				sg[p] = (p == len - 1) && ($urandom_range(0, 4) == 0);
			end
		end
		// For well-formed headers with skipping on, fill in a correct checksum field half the time
		if (kind < 60 && cfg_skip_en && $urandom_range(0, 1)) begin
			acc = '0;
			for (int p = 0; p < len; p++) begin
				if (p != int'(cfg_skip_idx)) begin
					acc = add_carry(acc, {hi_b[p], sg[p] ? byte_t'(0) : lo_b[p]});
				end
			end
			fld                = ~acc;
			hi_b[cfg_skip_idx] = fld[ihc_pkg::WordW-1:ihc_pkg::ByteW];
			lo_b[cfg_skip_idx] = fld[ihc_pkg::ByteW-1:0];
			sg[cfg_skip_idx]   = 1'b0;
		end
		for (int p = 0; p < len; p++) begin
			push_word(hi_b[p], lo_b[p], sg[p], p == len - 1, 1'b0, '0, 1'b0);
		end
	endtask

	// Receiver: stall at random, compare each item with the oldest expectation
	always @(posedge clk) begin : sum_check
		sum_rec_t want;
		sum_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		if (arst_n && sum_bus.valid && sum_bus.ready) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected result: checksum %h field_matches %b",
					sum_bus.checksum, sum_bus.field_matches);
				mismatch_cnt++;
			end else begin
				want = pending_sums.pop_front();
				if (sum_bus.checksum !== want.ck) begin
					$error("checksum: expected %h, got %h", want.ck, sum_bus.checksum);
					mismatch_cnt++;
				end
				if (sum_bus.field_matches !== want.m) begin
					$error("field_matches: expected %b, got %b", want.m,
						sum_bus.field_matches);
					mismatch_cnt++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int seg_end;
		int idx_val;
		arst_n              <= 1'b0;
		hdr_bus.valid       <= 1'b0;
		hdr_bus.first_byte  <= '0;
		hdr_bus.second_byte <= '0;
		hdr_bus.single_byte <= 1'b0;
		hdr_bus.last        <= 1'b0;
		cfg_bus.valid       <= 1'b0;
		cfg_bus.index       <= '0;
		cfg_bus.data        <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed headers under the reset configuration
		tx_idle_pct = seg_tx[0];
		rx_idle_pct = seg_rx[0];
		foreach (directed_rows[r]) begin
			push_word(directed_rows[r].fb, directed_rows[r].sb, directed_rows[r].single,
				directed_rows[r].lst, directed_rows[r].fixed, directed_rows[r].ck,
				directed_rows[r].m);
		end

		for (int s = 0; s < SEG_COUNT; s++) begin
			drain_sums();
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (s == 0) begin
				write_reg(CFG_SPARE_LO, $urandom);
				write_reg(CFG_SPARE_HI, $urandom);
			end
			idx_val = (seg_idx[s] == RANDOM_IDX) ? $urandom_range(0, 31) : seg_idx[s];
			write_reg(ihc_pkg::CFG_SKIP_ENABLE, ($urandom & ~32'h1) | 32'(seg_en[s]));
			write_reg(ihc_pkg::CFG_SKIP_INDEX, ($urandom & ~32'h1F) | 32'(idx_val));
			tx_idle_pct = seg_tx[s];
			rx_idle_pct = seg_rx[s];
			seg_end = items_sent + SEG_ITEMS;
			while (items_sent < seg_end) begin
				send_header();
				if ($urandom_range(0, 19) == 0) begin
					drain_sums();
				end
			end
		end

		drain_sums();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: ipv4_header_checksum.f
design/ihc_pkg.sv
design/ihc_if.sv
design/ipv4_header_checksum.sv
design/ihc_checker.sv
tb/testbench.sv
